// File: hw/rtl/hrbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrbf_pkg
// shared types and constants for the request body framer
// ----------------------------------------------------------------------------
package hrbf_pkg;

    localparam int unsigned LimitWidth = 32;
    localparam int unsigned QueueDepth = 2;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_CSIZE  = 3'd2;
    localparam logic [2:0] PH_CDATA  = 3'd3;
    localparam logic [2:0] PH_CGAP   = 3'd4;
    localparam logic [2:0] PH_CLAST  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [5:0] LM_CL_FULL   = 6'd14;
    localparam logic [5:0] LM_TE_FIRST  = 6'd15;
    localparam logic [5:0] LM_TE_FULL   = 6'd31;
    localparam logic [5:0] LM_IGNORE    = 6'd32;
    localparam logic [5:0] LM_CL_SKIP   = 6'd33;
    localparam logic [5:0] LM_CL_DIGITS = 6'd34;
    localparam logic [5:0] LM_TE_VALUE  = 6'd36;

    localparam logic [1:0] ST_RECV    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // one request as passed on by the front part
    typedef struct packed {
        logic       restart;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic [1:0] status;
        logic       is_chunked;
    } rsp_t;

    function automatic logic [7:0] key_len_char(input logic [5:0] i);
        logic [7:0] c;
        begin
            case (i)
                6'd0: c = "C";  6'd1: c = "o";  6'd2: c = "n";  6'd3: c = "t";
                6'd4: c = "e";  6'd5: c = "n";  6'd6: c = "t";  6'd7: c = "-";
                6'd8: c = "L";  6'd9: c = "e";  6'd10: c = "n"; 6'd11: c = "g";
                6'd12: c = "t"; 6'd13: c = "h";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] key_enc_char(input logic [5:0] i);
        logic [7:0] c;
        begin
            case (i)
                6'd0: c = "T";  6'd1: c = "r";  6'd2: c = "a";  6'd3: c = "n";
                6'd4: c = "s";  6'd5: c = "f";  6'd6: c = "e";  6'd7: c = "r";
                6'd8: c = "-";  6'd9: c = "E";  6'd10: c = "n"; 6'd11: c = "c";
                6'd12: c = "o"; 6'd13: c = "d"; 6'd14: c = "i"; 6'd15: c = "n";
                6'd16: c = "g";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] word_chk_char(input logic [2:0] i);
        logic [7:0] c;
        begin
            case (i)
                3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "u"; 3'd3: c = "n";
                3'd4: c = "k"; 3'd5: c = "e"; 3'd6: c = "d";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hrbf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrbf_queue
// small request queue between the front and the back part
// ----------------------------------------------------------------------------
module hrbf_queue #(
    parameter int unsigned Depth = hrbf_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hrbf_pkg::req_t wdata,
    output logic               full,
    input  wire logic          pop,
    output hrbf_pkg::req_t     rdata,
    output logic               not_empty
);
    import hrbf_pkg::*;

    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    req_t mem [Depth];
    logic [Aw-1:0] wp_reg, rp_reg;
    logic [Aw:0]   cnt_reg;

    assign full      = (cnt_reg == (Aw+1)'(Depth));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == Aw'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == Aw'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/hrbf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrbf_front
// input side: accepts requests and pushes them into the queue
// ----------------------------------------------------------------------------
module hrbf_front (
    input  wire logic           valid,
    output logic                stall,
    input  wire logic           restart,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           q_full,
    output logic                q_push,
    output hrbf_pkg::req_t      q_wdata
);
    import hrbf_pkg::*;

    assign stall           = q_full;
    assign q_push          = valid && !q_full;
    assign q_wdata.restart = restart;
    assign q_wdata.rx_byte = rx_byte;
endmodule
`default_nettype wire

// File: hw/rtl/hrbf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrbf_back
// framing engine: header matching, length and chunk framing, output register
// ----------------------------------------------------------------------------
module hrbf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    max_body_bytes,
    input  wire logic           q_not_empty,
    input  wire hrbf_pkg::req_t q_rdata,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output hrbf_pkg::rsp_t      rsp
);
    import hrbf_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [23:0] recent_reg, recent_next;
    logic [5:0]  lm_reg, lm_next;
    logic [2:0]  cpos_reg, cpos_next;
    logic [31:0] dlen_reg, dlen_next;
    logic        chk_reg, chk_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        ov_reg;
    rsp_t        rsp_reg, rsp_next;

    // working copies after restart
    logic [2:0]  ph;
    logic [23:0] p3;
    logic [5:0]  lm;
    logic [2:0]  cp;
    logic [31:0] dl, ac, lf, bc;
    logic        cf;
    logic [7:0]  ch;
    logic [4:0]  hv;
    logic        hv_ok, ws, dig;
    logic [35:0] mul10;
    logic        take;

    assign take      = q_not_empty && (!ov_reg || !out_stall);
    assign q_pop     = take;
    assign out_valid = ov_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        ch    = q_rdata.rx_byte;
        ph    = q_rdata.restart ? PH_HEADER : phase_reg;
        p3    = q_rdata.restart ? '0 : recent_reg;
        lm    = q_rdata.restart ? '0 : lm_reg;
        cp    = q_rdata.restart ? '0 : cpos_reg;
        dl    = q_rdata.restart ? '0 : dlen_reg;
        cf    = q_rdata.restart ? 1'b0 : chk_reg;
        ac    = q_rdata.restart ? '0 : acc_reg;
        lf    = q_rdata.restart ? '0 : left_reg;
        bc    = q_rdata.restart ? '0 : cnt_reg;
        ws    = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
        dig   = (ch >= "0" && ch <= "9");
        hv_ok = 1'b1;
        hv    = '0;
        if (dig)
            hv = 5'(ch - "0");
        else if (ch >= "a" && ch <= "f")
            hv = 5'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F")
            hv = 5'(ch - "A" + 8'd10);
        else
            hv_ok = 1'b0;
        mul10 = {4'd0, ac} * 36'd10 + 36'(ch - "0");
        recent_next   = {p3[15:0], ch};
        rsp_next      = '0;
        phase_next    = ph;
        lm_next       = lm;
        cpos_next     = cp;
        dlen_next     = dl;
        chk_next      = cf;
        acc_next      = ac;
        left_next     = lf;
        cnt_next      = bc;

        case (ph)
            PH_HEADER:
            begin
                if (ch == 8'h0A)
                begin
                    lm_next   = '0;
                    cpos_next = '0;
                end
                else if (lm <= LM_TE_FULL)
                begin
                    if (ch == ":")
                    begin
                        if (lm == LM_CL_FULL)
                        begin
                            acc_next  = '0;
                            dlen_next = '0;
                            lm_next   = LM_CL_SKIP;
                        end
                        else if (lm == LM_TE_FULL)
                        begin
                            cpos_next = '0;
                            lm_next   = LM_TE_VALUE;
                        end
                        else
                            lm_next = LM_IGNORE;
                    end
                    else if (lm == 6'd0)
                        lm_next = (ch == "C") ? 6'd1 : (ch == "T") ? LM_TE_FIRST : LM_IGNORE;
                    else if (lm < LM_CL_FULL)
                        lm_next = (ch == key_len_char(lm)) ? lm + 6'd1 : LM_IGNORE;
                    else if (lm >= LM_TE_FIRST && lm < LM_TE_FULL)
                        lm_next = (ch == key_enc_char(lm - 6'd14)) ? lm + 6'd1 : LM_IGNORE;
                    else
                        lm_next = LM_IGNORE;
                end
                else if (lm == LM_CL_SKIP || lm == LM_CL_DIGITS)
                begin
                    if (dig)
                    begin
                        // saturating decimal accumulate
                        acc_next  = (mul10[35:32] != '0) ? 32'hFFFF_FFFF : mul10[31:0];
                        dlen_next = acc_next;
                        lm_next   = LM_CL_DIGITS;
                    end
                    else if (!(lm == LM_CL_SKIP && ws))
                        lm_next = LM_IGNORE;
                end
                else if (lm == LM_TE_VALUE)
                begin
                    if (cp < 3'd7 && ch == word_chk_char(cp))
                        cpos_next = cp + 3'd1;
                    else
                        cpos_next = (ch == "c") ? 3'd1 : 3'd0;
                    if (cpos_next == 3'd7)
                    begin
                        chk_next  = 1'b1;
                        cpos_next = '0;
                        lm_next   = LM_IGNORE;
                    end
                end
                // header end
                if (p3 == 24'h0D0A0D && ch == 8'h0A)
                begin
                    cnt_next = '0;
                    if (max_body_bytes != '0 && dlen_next > max_body_bytes)
                    begin
                        rsp_next.status = ST_TOOBIG;
                        phase_next      = PH_DONE;
                    end
                    else if (chk_next)
                    begin
                        phase_next  = PH_CSIZE;
                        lm_next     = '0;
                        acc_next    = '0;
                        recent_next = '0;
                    end
                    else if (dlen_next != '0)
                        phase_next = PH_LENGTH;
                    else
                    begin
                        rsp_next.status = ST_DONE;
                        phase_next      = PH_DONE;
                    end
                end
            end
            PH_LENGTH:
            begin
                rsp_next.body_valid = 1'b1;
                rsp_next.body_byte  = ch;
                if (bc != 32'hFFFF_FFFF)
                    cnt_next = bc + 32'd1;
                if (cnt_next >= dl)
                begin
                    rsp_next.status = ST_DONE;
                    phase_next      = PH_DONE;
                end
            end
            PH_CSIZE:
            begin
                if (ch == 8'h0A && p3[7:0] == 8'h0D)
                begin
                    if (ac == '0)
                    begin
                        left_next  = 32'd2;
                        phase_next = PH_CLAST;
                    end
                    else
                    begin
                        left_next  = ac;
                        phase_next = PH_CDATA;
                    end
                end
                else
                begin
                    case (lm)
                        6'd0:
                        begin
                            if (!ws)
                            begin
                                if (hv_ok)
                                begin
                                    acc_next = 32'(hv);
                                    lm_next  = (hv == '0) ? 6'd1 : 6'd2;
                                end
                                else
                                    lm_next = 6'd3;
                            end
                        end
                        6'd1, 6'd2:
                        begin
                            if (lm == 6'd1 && (ch == "x" || ch == "X"))
                                lm_next = 6'd2;
                            else if (hv_ok)
                            begin
                                acc_next = (ac > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF
                                                                : {ac[27:0], hv[3:0]};
                                lm_next  = 6'd2;
                            end
                            else
                                lm_next = 6'd3;
                        end
                        default:
                            lm_next = 6'd3;
                    endcase
                end
            end
            PH_CDATA:
            begin
                if (max_body_bytes != '0 && bc >= max_body_bytes)
                begin
                    rsp_next.status = ST_TOOBIG;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    rsp_next.body_valid = 1'b1;
                    rsp_next.body_byte  = ch;
                    if (bc != 32'hFFFF_FFFF)
                        cnt_next = bc + 32'd1;
                    if (lf != '0)
                        left_next = lf - 32'd1;
                    if (left_next == '0)
                    begin
                        left_next  = 32'd2;
                        phase_next = PH_CGAP;
                    end
                end
            end
            PH_CGAP:
            begin
                if (lf != '0)
                    left_next = lf - 32'd1;
                if (left_next == '0)
                begin
                    phase_next  = PH_CSIZE;
                    lm_next     = '0;
                    acc_next    = '0;
                    recent_next = '0;
                end
            end
            PH_CLAST:
            begin
                if (lf != '0)
                    left_next = lf - 32'd1;
                if (left_next == '0)
                begin
                    rsp_next.status = ST_DONE;
                    phase_next      = PH_DONE;
                end
            end
            default:
            begin
                phase_next      = PH_DONE;
                rsp_next.status = ST_IGNORED;
            end
        endcase
        rsp_next.is_chunked = chk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            recent_reg <= '0;
            lm_reg     <= '0;
            cpos_reg   <= '0;
            dlen_reg   <= '0;
            chk_reg    <= 1'b0;
            acc_reg    <= '0;
            left_reg   <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                recent_reg <= recent_next;
                lm_reg     <= lm_next;
                cpos_reg   <= cpos_next;
                dlen_reg   <= dlen_next;
                chk_reg    <= chk_next;
                acc_reg    <= acc_next;
                left_reg   <= left_next;
                cnt_reg    <= cnt_next;
                ov_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/http_request_body_framer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_body_framer_unit
// frames the body of an http/1.1 request, one byte per request
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with restart and rx_byte; a request is
//   taken at an edge with in_valid high and in_stall low
// output channel: out_valid/out_stall with body_valid, body_byte, status and
//   is_chunked; exactly one result per input request, in order
// config: max_body_bytes is written when cfg_we is high (0 = no limit)
// path: an accepted request is written into the queue, then taken by the
//   framing engine and lands in its output register, which drives out_valid
// throughput: one byte per cycle while out_stall is low, set by the combinational framing step
// a stalled output holds; the two-entry queue fills and then in_stall rises
// reset clears parser state and the limit; restart in a request clears
//   parser state only, before that byte is handled
// ----------------------------------------------------------------------------
module http_request_body_framer_unit #(
    parameter int unsigned QueueDepth = hrbf_pkg::QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        restart,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             body_valid,
    output logic [7:0]       body_byte,
    output logic [1:0]       status,
    output logic             is_chunked
);
    import hrbf_pkg::*;

    logic [LimitWidth-1:0] limit_reg;
    logic q_push, q_full, q_pop, q_ne;
    req_t q_wdata, q_rdata;
    rsp_t rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    hrbf_front u_front (
        .valid   (in_valid),
        .stall   (in_stall),
        .restart (restart),
        .rx_byte (rx_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    hrbf_queue #(.Depth(QueueDepth)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_ne)
    );

    hrbf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_body_bytes (limit_reg),
        .q_not_empty    (q_ne),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rsp            (rsp)
    );

    assign body_valid = rsp.body_valid;
    assign body_byte  = rsp.body_byte;
    assign status     = rsp.status;
    assign is_chunked = rsp.is_chunked;

    // a body byte is only reported with status recv or done
    a_body_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid |-> status == ST_RECV || status == ST_DONE)
        else $error("body byte with bad status");

    // no body byte carries a value when not valid
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !body_valid |-> body_byte == 8'd0)
        else $error("stray body byte");

    // the queue is never popped empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_ne)
        else $error("queue underflow");
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// checks the http request body framer against a built-in model of its
// header matching, length and chunked framing and size limit, with
// directed requests, random well-formed and broken requests and idling
// ----------------------------------------------------------------------------
module tb;
    import hrbf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        restart = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [1:0]  status;
    logic        is_chunked;

    http_request_body_framer_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .rx_byte(rx_byte), .out_valid(out_valid), .out_stall(out_stall),
        .body_valid(body_valid), .body_byte(body_byte), .status(status),
        .is_chunked(is_chunked)
    );

    always #6 clk = ~clk;

    // model state
    logic [31:0] m_limit;
    logic [2:0]  m_phase;
    logic [23:0] m_recent;
    logic [5:0]  m_lm;
    logic [2:0]  m_cpos;
    logic [31:0] m_decl;
    logic        m_chunked;
    logic [31:0] m_accum;
    logic [31:0] m_left;
    logic [31:0] m_count;

    rsp_t expected_q[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   sent = 0;
    int   checked = 0;
    int   bodies = 0;
    int   finishes = 0;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void clear_parser();
        m_phase = PH_HEADER;
        m_recent = '0;
        m_lm = '0;
        m_cpos = '0;
        m_decl = '0;
        m_chunked = 1'b0;
        m_accum = '0;
        m_left = '0;
        m_count = '0;
    endfunction

    function automatic void header_step(input logic [7:0] c);
        logic [5:0] lm;
        logic [2:0] p;
        lm = m_lm;
        if (c == 8'h0a) begin
            m_lm = '0;
            m_cpos = '0;
            return;
        end
        if (lm <= LM_TE_FULL) begin
            if (c == ":") begin
                if (lm == LM_CL_FULL) begin
                    m_accum = '0;
                    m_decl = '0;
                    lm = LM_CL_SKIP;
                end else if (lm == LM_TE_FULL) begin
                    m_cpos = '0;
                    lm = LM_TE_VALUE;
                end else begin
                    lm = LM_IGNORE;
                end
            end else if (lm == 0) begin
                lm = (c == "C") ? 6'd1 : (c == "T") ? LM_TE_FIRST : LM_IGNORE;
            end else if (lm < LM_CL_FULL) begin
                lm = (c == key_len_char(lm)) ? lm + 6'd1 : LM_IGNORE;
            end else if (lm >= LM_TE_FIRST && lm < LM_TE_FULL) begin
                lm = (c == key_enc_char(lm - 6'd14)) ? lm + 6'd1 : LM_IGNORE;
            end else begin
                lm = LM_IGNORE;
            end
        end else if (lm == LM_CL_SKIP || lm == LM_CL_DIGITS) begin
            if (c >= "0" && c <= "9") begin
                if (m_accum > 32'd429496729 || (m_accum == 32'd429496729 && c > "5"))
                    m_accum = '1;
                else
                    m_accum = m_accum * 10 + (c - "0");
                m_decl = m_accum;
                lm = LM_CL_DIGITS;
            end else if (!(lm == LM_CL_SKIP && is_space(c))) begin
                lm = LM_IGNORE;
            end
        end else if (lm == LM_TE_VALUE) begin
            p = m_cpos;
            if (p < 7 && c == word_chk_char(p)) p = p + 3'd1;
            else p = (c == "c") ? 3'd1 : 3'd0;
            if (p == 7) begin
                m_chunked = 1'b1;
                p = '0;
                lm = LM_IGNORE;
            end
            m_cpos = p;
        end
        m_lm = lm;
    endfunction

    function automatic void size_step(input logic [7:0] c);
        int d;
        d = hex_digit(c);
        case (m_lm)
            6'd0: if (!is_space(c)) begin
                if (d >= 0) begin
                    m_accum = 32'(d);
                    m_lm = (d == 0) ? 6'd1 : 6'd2;
                end else m_lm = 6'd3;
            end
            6'd1: if (c == "x" || c == "X") m_lm = 6'd2;
                else if (d >= 0) begin
                    m_accum = (m_accum > 32'h0fffffff) ? '1 : {m_accum[27:0], 4'(d)};
                    m_lm = 6'd2;
                end else m_lm = 6'd3;
            6'd2: if (d >= 0)
                    m_accum = (m_accum > 32'h0fffffff) ? '1 : {m_accum[27:0], 4'(d)};
                else m_lm = 6'd3;
            default: m_lm = 6'd3;
        endcase
    endfunction

    function automatic void begin_size_line();
        m_phase = PH_CSIZE;
        m_lm = '0;
        m_accum = '0;
        m_recent = '0;
    endfunction

    function automatic rsp_t frame_byte(input logic rs, input logic [7:0] c);
        rsp_t r;
        logic [23:0] prev;
        r = '0;
        if (rs) clear_parser();
        prev = m_recent;
        m_recent = {prev[15:0], c};
        case (m_phase)
            PH_HEADER: begin
                header_step(c);
                if (prev == 24'h0d0a0d && c == 8'h0a) begin
                    m_count = '0;
                    if (m_limit != 0 && m_decl > m_limit) begin
                        r.status = ST_TOOBIG;
                        m_phase = PH_DONE;
                    end else if (m_chunked) begin
                        begin_size_line();
                    end else if (m_decl > 0) begin
                        m_phase = PH_LENGTH;
                    end else begin
                        r.status = ST_DONE;
                        m_phase = PH_DONE;
                    end
                end
            end
            PH_LENGTH: begin
                r.body_valid = 1'b1;
                r.body_byte = c;
                if (m_count != '1) m_count++;
                if (m_count >= m_decl) begin
                    r.status = ST_DONE;
                    m_phase = PH_DONE;
                end
            end
            PH_CSIZE: begin
                if (c == 8'h0a && prev[7:0] == 8'h0d) begin
                    if (m_accum == 0) begin
                        m_left = 2;
                        m_phase = PH_CLAST;
                    end else begin
                        m_left = m_accum;
                        m_phase = PH_CDATA;
                    end
                end else size_step(c);
            end
            PH_CDATA: begin
                if (m_limit != 0 && m_count >= m_limit) begin
                    r.status = ST_TOOBIG;
                    m_phase = PH_DONE;
                end else begin
                    r.body_valid = 1'b1;
                    r.body_byte = c;
                    if (m_count != '1) m_count++;
                    if (m_left != 0) m_left--;
                    if (m_left == 0) begin
                        m_left = 2;
                        m_phase = PH_CGAP;
                    end
                end
            end
            PH_CGAP: begin
                if (m_left != 0) m_left--;
                if (m_left == 0) begin_size_line();
            end
            PH_CLAST: begin
                if (m_left != 0) m_left--;
                if (m_left == 0) begin
                    r.status = ST_DONE;
                    m_phase = PH_DONE;
                end
            end
            default: begin
                m_phase = PH_DONE;
                r.status = ST_IGNORED;
            end
        endcase
        r.is_chunked = m_chunked;
        return r;
    endfunction

    task automatic send_byte(input logic rs, input logic [7:0] c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        rx_byte <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.insert(expected_q.size(), frame_byte(rs, c));
        sent++;
    endtask

    task automatic send_text(input logic rs, input string s);
        for (int i = 0; i < s.len(); i++) send_byte(rs && i == 0, s[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_limit = v;
    endtask

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            rsp_t got;
            rsp_t exp;
            got = '{body_valid, body_byte, status, is_chunked};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp = expected_q.pop_front();
                checked++;
                if (got.body_valid) bodies++;
                if (got.status == ST_DONE) finishes++;
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v=%b b=%h s=%0d c=%b, got v=%b b=%h s=%0d c=%b",
                            exp.body_valid, exp.body_byte, exp.status, exp.is_chunked,
                            got.body_valid, got.body_byte, got.status, got.is_chunked);
                end
            end
        end
        if (recv_stall_pct > 0) out_stall <= ($urandom_range(99) < recv_stall_pct);
        else out_stall <= 1'b0;
    end

    function automatic string hex_str(input logic [31:0] v);
        return $sformatf("%0h", v);
    endfunction

    task automatic test_directed();
        // length framing, sign before a number, saturating length
        send_text(1, "POST / HTTP/1.1\r\nContent-Length: 3\r\n\r\nab\xffzz");
        send_text(1, "X\r\nContent-Length:+5\r\n\r\nq");
        send_text(1, "\r\n\r\nContent-Length: 99999999999\r\n\r\n");
        // chunked with 0x prefix, extension, terminating chunk
        send_text(1, "Transfer-Encoding: gzip, chunked\r\n\r\n0x2;e=1\r\nhi\r\n0\r\n\r\n.");
        write_limit(32'd3);
        send_text(1, "Transfer-Encoding: chunked\r\n\r\n5\r\nabcde\r\n");
        send_text(1, "Content-Length: 4\r\n\r\n");
        send_byte(1, 8'h00);
        send_byte(0, 8'hff);
        write_limit(32'hffffffff);
        send_text(1, "content-length: 2\r\n\r\n");
    endtask

    function automatic string random_headers(output int len, output logic ch);
        string s;
        s = "GET /x HTTP/1.1\r\n";
        len = $urandom_range(0, 12);
        ch = ($urandom_range(2) == 0);
        if ($urandom_range(4) == 0) s = {s, "Content-Length: 7\r\n"};
        if (ch) s = {s, "Transfer-Encoding: chunked\r\n"};
        else if ($urandom_range(3) == 0) s = {s, "Transfer-Encoding: chunk\r\n"};
        s = {s, $sformatf("Content-Length:%s%0d\r\n", ($urandom_range(1)) ? " " : "", len)};
        if ($urandom_range(3) == 0) s = {s, "Host: a\rb\r\n"};
        return {s, "\r\n"};
    endfunction

    task automatic test_random(input int count);
        int len;
        logic ch;
        int n;
        while (sent < count) begin
            send_text(1, random_headers(len, ch));
            if (ch) begin
                repeat ($urandom_range(0, 3)) begin
                    n = $urandom_range(1, 9);
                    send_text(0, {($urandom_range(1)) ? "0x" : "", hex_str(n),
                        ($urandom_range(2) == 0) ? ";x\r" : "", "\r\n"});
                    repeat (n) send_byte(0, 8'($urandom));
                    send_text(0, "\r\n");
                end
                send_text(0, "0\r\n\r\n");
            end else begin
                repeat (len) send_byte(0, 8'($urandom));
            end
            // trailing noise: ignored bytes or a broken stream
            repeat ($urandom_range(0, 3)) send_byte(0, 8'($urandom));
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 20)) send_byte($urandom_range(15) == 0, 8'($urandom));
        end
    endtask

    task automatic test_idling();
        int phase_items;
        phase_items = 400;
        test_random(sent + phase_items);
        send_idle_pct = 47;
        write_limit(32'd5);
        test_random(sent + phase_items);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        write_limit(32'd0);
        test_random(sent + phase_items);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        write_limit(32'd10);
        test_random(sent + phase_items);
        // sender waits for all results before going on
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_limit(32'd0);
        test_random(sent + phase_items);
    endtask

    initial begin
        m_limit = '0;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idling();
        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d bytes, checked %0d results, %0d body bytes, %0d requests done",
            sent, checked, bodies, finishes);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout");
        $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
